/* rtl/ltc_pkg.sv */
package ltc_pkg;

  localparam int CHAR_W       = 8;
  localparam int CLS_W        = 5;
  localparam int PREFIX_DEPTH = 7;
  localparam int CNT_W        = 4;
  localparam int SINGLE_COUNT = 13;
  localparam int KW_COUNT     = 11;
  localparam int KW_MAX_LEN   = 7;

  typedef logic [CHAR_W-1:0]                    char_t;
  typedef logic [CLS_W-1:0]                     cls_t;
  typedef logic [CNT_W-1:0]                     cnt_t;
  typedef logic [PREFIX_DEPTH-1:0][CHAR_W-1:0]  prefix_t;
  typedef logic [7:0]                           out_tdata_t;

  localparam cnt_t COUNT_MAX = 4'd8;

  localparam char_t CH_EQ   = 8'h3d;
  localparam char_t CH_DOT  = 8'h2e;
  localparam char_t CH_BAR  = 8'h7c;
  localparam char_t CH_AMP  = 8'h26;
  localparam char_t CH_ZERO = 8'h30;
  localparam char_t CH_NINE = 8'h39;
  localparam char_t CH_LO_O = 8'h6f;
  localparam char_t CH_LO_F = 8'h66;

  localparam cls_t CLS_ERROR   = 5'd0;
  localparam cls_t CLS_RANGE   = 5'd14;
  localparam cls_t CLS_OF      = 5'd15;
  localparam cls_t CLS_INT     = 5'd16;
  localparam cls_t CLS_REAL    = 5'd17;
  localparam cls_t CLS_KW_BASE = 5'd18;
  localparam cls_t CLS_IDENT   = 5'd29;

  // single-char operators, class is index plus one
  localparam char_t SINGLE_CHARS [0:SINGLE_COUNT-1] = '{
    CH_EQ, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h7b, 8'h7d, 8'h5b, 8'h5d,
    8'h28, 8'h29, 8'h3b, 8'h3a
  };

  // keyword text right-aligned, first char in the highest used byte
  localparam logic [KW_MAX_LEN*CHAR_W-1:0] KW_TEXT [0:KW_COUNT-1] = '{
    56'({CH_BAR, CH_BAR, CH_BAR}), 56'({CH_AMP, CH_AMP, CH_AMP}),
    56'("declare"), 56'("integer"), 56'("boolean"),
    56'("size"), 56'("real"), 56'("list"), 56'("array"),
    56'("jagged"), 56'("values")
  };
  localparam int KW_LEN [0:KW_COUNT-1] = '{3, 3, 7, 7, 7, 4, 4, 4, 5, 6, 6};

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input char_t c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic cls_t classify(input prefix_t p, input cnt_t len,
                                    input logic dot, input logic bad);
    cls_t  cls;
    logic  done;
    logic  match;
    int    j;
    cls  = CLS_ERROR;
    done = 1'b0;
    if (len == 4'd1) begin
      for (int i = 0; i < SINGLE_COUNT; i++) begin
        if (!done && (p[0] == SINGLE_CHARS[i])) begin
          cls  = CLS_W'(i + 1);
          done = 1'b1;
        end
      end
    end
    if (!done && (len == 4'd2)) begin
      if ((p[0] == CH_DOT) && (p[1] == CH_DOT)) begin
        cls  = CLS_RANGE;
        done = 1'b1;
      end else if ((p[0] == CH_LO_O) && (p[1] == CH_LO_F)) begin
        cls  = CLS_OF;
        done = 1'b1;
      end
    end
    if (!done && is_digit(p[0])) begin
      cls  = bad ? CLS_ERROR : (dot ? CLS_REAL : CLS_INT);
      done = 1'b1;
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      match = (len == CNT_W'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < KW_LEN[k]) begin
          j = KW_LEN[k] - 1 - i;
          if (p[i] != KW_TEXT[k][j*CHAR_W +: CHAR_W]) begin
            match = 1'b0;
          end
        end
      end
      if (!done && match) begin
        cls  = CLS_KW_BASE + CLS_W'(k);
        done = 1'b1;
      end
    end
    if (!done && is_letter(p[0])) begin
      cls = CLS_IDENT;
    end
    return cls;
  endfunction

endpackage

/* rtl/lexeme_token_classifier_unit.sv */
// out_tvalid rises once the last character passes the character and result registers
// throughput: one character per cycle, sustained while the output is taken
// the limit is the single classify stage between the character register and result register
// reset (rst_n low, synchronous) clears valid flags, length count and number flags;
// stored prefix characters are not reset
module lexeme_token_classifier_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] char_code
  input  logic                in_tlast,   // is_last
  output logic                out_tvalid,
  input  logic                out_tready,
  output ltc_pkg::out_tdata_t out_tdata   // [4:0] token_class, [7:5] zero
);
  import ltc_pkg::*;

  char_t   s1_chr_r;
  logic    s1_last_r;
  logic    s1_vld_r;
  prefix_t pfx_r;
  prefix_t pfx_nxt;
  cnt_t    count_r;
  cnt_t    count_nxt;
  logic    dot_r;
  logic    dot_nxt;
  logic    bad_r;
  logic    bad_nxt;
  cls_t    out_cls_r;
  logic    out_vld_r;
  logic    out_free;
  logic    s1_go;
  logic    in_fire;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_go     = s1_vld_r && (!s1_last_r || out_free);
  assign in_tready = !s1_vld_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    pfx_nxt   = pfx_r;
    count_nxt = count_r;
    dot_nxt   = dot_r;
    bad_nxt   = bad_r;
    if (count_r < CNT_W'(PREFIX_DEPTH)) begin
      pfx_nxt[count_r[2:0]] = s1_chr_r;
    end
    if (count_r < COUNT_MAX) begin
      count_nxt = count_r + 4'd1;
    end
    if (s1_chr_r == CH_DOT) begin
      if (dot_r) begin
        bad_nxt = 1'b1;
      end else begin
        dot_nxt = 1'b1;
      end
    end else if (!is_digit(s1_chr_r)) begin
      bad_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      count_r   <= '0;
      dot_r     <= 1'b0;
      bad_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last_r) begin
          count_r <= '0;
          dot_r   <= 1'b0;
          bad_r   <= 1'b0;
        end else begin
          count_r <= count_nxt;
          dot_r   <= dot_nxt;
          bad_r   <= bad_nxt;
        end
      end
      if (s1_go && s1_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_chr_r  <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go) begin
      pfx_r <= pfx_nxt;
    end
    if (s1_go && s1_last_r) begin
      out_cls_r <= classify(pfx_nxt, count_nxt, dot_nxt, bad_nxt);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_cls_r};

endmodule
